// ===== sv/clt_pkg.sv =====
// Shared types and constants for the command line tokenizer.
// Request and result structs, operation and event codes, memory geometry.
// No dependencies.
package clt_pkg;

  // Table and line sizes; the port field widths are sized for these values.
  localparam int TOKENS_MAX = 8;
  localparam int LINE_CAP   = 32;

  localparam logic [7:0] ESC_RESET = 8'd27;

  // Ring position within the token table.
  localparam int TIX_W = (TOKENS_MAX > 1) ? $clog2(TOKENS_MAX) : 1;
  // Token count, 0..TOKENS_MAX.
  localparam int CNT_W = $clog2(TOKENS_MAX + 1);
  // Physical slot, 0..TOKENS_MAX (one spare slot holds the line being typed).
  localparam int PHY_W = $clog2(TOKENS_MAX + 1);
  // Line length and character position, 0..LINE_CAP-1.
  localparam int LEN_W = $clog2(LINE_CAP);

  localparam int CHR_DEPTH = (TOKENS_MAX + 1) << LEN_W;
  localparam int TBL_DEPTH = TOKENS_MAX;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_EAT  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_APPEND   = 3'd1;
  localparam logic [2:0] EV_COMMIT   = 3'd2;
  localparam logic [2:0] EV_ESCAPE   = 3'd3;
  localparam logic [2:0] EV_OVERFLOW = 3'd4;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_in;
    logic [3:0] eat_count;
    logic [2:0] token_index;
    logic [4:0] char_position;
  } clt_in_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] echo_char;
    logic [3:0] token_count;
    logic [7:0] read_char;
    logic       read_valid;
  } clt_out_t;

  // One entry of the slot table: where a token lives and how long it is.
  typedef struct packed {
    logic [PHY_W-1:0] phys;
    logic [LEN_W-1:0] len;
  } clt_slot_t;

endpackage

// ===== sv/clt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module clt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/command_line_tokenizer.sv =====
// Command line tokenizer top level: request sequencer, slot renaming, output register.
// Depends on clt_pkg and clt_ram.
//
// Takes one request at a time and returns exactly one result per request.
// A request is accepted in ST_IDLE and runs through ST_EXEC to ST_OUT; the
// block is ready again once ST_OUT has handed its result over. Appending a
// character, whitespace on an empty line, escape, eat, the unused code and
// reads with an index beyond the count go from ST_EXEC straight to ST_OUT;
// a token commit and a read past the end of its token also pass ST_TBL; a
// read that fetches a character passes ST_TBL and then ST_CHR. These extra
// steps come from the two synchronous memories, each with registered
// read data: a commit reads then writes the slot table, a
// read walks the slot table and then the character memory. The character
// memory has TOKENS_MAX+1 rows of 2**LEN_W bytes; the spare row holds the
// line being typed. A commit does not copy any characters: the line's row
// is swapped into the slot table at the new token's ring position, and the
// row it displaces (free or just dropped) becomes the new line buffer. The
// slot table starts out as the identity map through per-entry valid bits,
// so there is no clearing pass after reset. Escape and overflow clear only
// the counters and pointers. The result waits in an output register, so a
// slow consumer stalls the sequencer only at its final step. The
// configuration port is always ready; the escape character should be
// written only while the block is idle.
module command_line_tokenizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  clt_pkg::clt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output clt_pkg::clt_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);

  import clt_pkg::*;

  localparam int CHR_AW = PHY_W + LEN_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] ST_EXEC = 3'd1;  // decode, simple updates, issue reads
  localparam logic [2:0] ST_TBL  = 3'd2;  // slot table data back
  localparam logic [2:0] ST_CHR  = 3'd3;  // character data back
  localparam logic [2:0] ST_OUT  = 3'd4;  // hand result to output register

  logic [2:0]        state_r, state_nxt;
  clt_in_t           item_r, item_nxt;
  logic [7:0]        esc_r, esc_nxt;
  logic [TIX_W-1:0]  oldest_r, oldest_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [LEN_W-1:0]  line_len_r, line_len_nxt;
  logic [PHY_W-1:0]  line_slot_r, line_slot_nxt;
  logic [TOKENS_MAX-1:0] tbl_vld_r, tbl_vld_nxt;
  logic [TIX_W-1:0]  pos_r, pos_nxt;
  clt_out_t          res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  clt_out_t          out_data_r, out_data_nxt;

  // Memory ports
  logic              tbl_we, tbl_re;
  clt_slot_t         tbl_wdata, tbl_rdata;
  logic [TIX_W-1:0]  tbl_raddr;
  logic              chr_we, chr_re;
  logic [CHR_AW-1:0] chr_waddr, chr_raddr;
  logic [7:0]        chr_wdata, chr_rdata;

  // Decode helpers
  logic [7:0]        ch_uc;
  logic              is_ws;
  logic              full;
  logic [CNT_W-1:0]  eat_n;
  clt_slot_t         entry;

  // Ring addition with a single wrap: base < TOKENS_MAX, step <= TOKENS_MAX.
  function automatic logic [TIX_W-1:0] ring_add(input logic [TIX_W-1:0] base,
                                                input logic [CNT_W-1:0] step);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(step);
    if (sum >= (CNT_W+1)'(TOKENS_MAX)) begin
      sum = sum - (CNT_W+1)'(TOKENS_MAX);
    end
    return TIX_W'(sum);
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Only ASCII a..z are uppercased; whitespace is space and TAB..CR.
  assign ch_uc = (item_r.char_in inside {[8'h61:8'h7a]}) ?
                 (item_r.char_in - 8'h20) : item_r.char_in;
  assign is_ws = item_r.char_in inside {8'h20, [8'h09:8'h0d]};
  assign full  = (count_r == CNT_W'(TOKENS_MAX));
  assign eat_n = (CNT_W'(item_r.eat_count) > count_r) ? count_r : CNT_W'(item_r.eat_count);

  // Never-written table entries read as the identity map with zero length.
  assign entry = tbl_vld_r[pos_r] ? tbl_rdata :
                 clt_slot_t'{phys: PHY_W'(pos_r), len: '0};

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    esc_nxt       = esc_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    line_len_nxt  = line_len_r;
    line_slot_nxt = line_slot_r;
    tbl_vld_nxt   = tbl_vld_r;
    pos_nxt       = pos_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    tbl_we    = 1'b0;
    tbl_re    = 1'b0;
    tbl_wdata = '{phys: line_slot_r, len: line_len_r};
    chr_we    = 1'b0;
    chr_re    = 1'b0;
    chr_waddr = {line_slot_r, line_len_r};
    chr_wdata = ch_uc;
    chr_raddr = {entry.phys, LEN_W'(item_r.char_position)};

    if (cfg_valid) begin
      esc_nxt = cfg_data;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          res_nxt   = '0;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_OUT;
        case (item_r.operation)
          OP_ADD: begin
            if (item_r.char_in == esc_r) begin
              count_nxt         = '0;
              oldest_nxt        = '0;
              line_len_nxt      = '0;
              res_nxt.event_res = EV_ESCAPE;
            end else if (is_ws) begin
              if (line_len_r != '0) begin
                // Full table: drop oldest, new token takes its ring place.
                if (full) begin
                  pos_nxt    = oldest_r;
                  oldest_nxt = ring_add(oldest_r, CNT_W'(1));
                end else begin
                  pos_nxt   = ring_add(oldest_r, count_r);
                  count_nxt = count_r + CNT_W'(1);
                end
                tbl_re            = 1'b1;
                res_nxt.event_res = EV_COMMIT;
                state_nxt         = ST_TBL;
              end
            end else begin
              chr_we            = 1'b1;
              res_nxt.echo_char = ch_uc;
              if (line_len_r == LEN_W'(LINE_CAP - 1)) begin
                count_nxt         = '0;
                oldest_nxt        = '0;
                line_len_nxt      = '0;
                res_nxt.event_res = EV_OVERFLOW;
              end else begin
                line_len_nxt      = line_len_r + LEN_W'(1);
                res_nxt.event_res = EV_APPEND;
              end
            end
          end
          OP_EAT: begin
            oldest_nxt = ring_add(oldest_r, eat_n);
            count_nxt  = count_r - eat_n;
          end
          OP_READ: begin
            if (CNT_W'(item_r.token_index) < count_r) begin
              pos_nxt            = ring_add(oldest_r, CNT_W'(item_r.token_index));
              tbl_re             = 1'b1;
              res_nxt.read_valid = 1'b1;
              state_nxt          = ST_TBL;
            end
          end
          default: begin
          end
        endcase
      end

      ST_TBL: begin
        if (item_r.operation == OP_READ) begin
          if (LEN_W'(item_r.char_position) < entry.len) begin
            chr_re    = 1'b1;
            state_nxt = ST_CHR;
          end else begin
            state_nxt = ST_OUT;
          end
        end else begin
          // Commit: swap the line row into the table, take the displaced row.
          tbl_we               = 1'b1;
          tbl_vld_nxt[pos_r]   = 1'b1;
          line_slot_nxt        = entry.phys;
          line_len_nxt         = '0;
          state_nxt            = ST_OUT;
        end
      end

      ST_CHR: begin
        res_nxt.read_char = chr_rdata;
        state_nxt         = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt             = res_r;
          out_data_nxt.token_count = 4'(count_r);
          state_nxt                = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Slot table is read at the ring position chosen above.
    tbl_raddr = pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      esc_r       <= ESC_RESET;
      oldest_r    <= '0;
      count_r     <= '0;
      line_len_r  <= '0;
      line_slot_r <= PHY_W'(TOKENS_MAX);
      tbl_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      esc_r       <= esc_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      line_len_r  <= line_len_nxt;
      line_slot_r <= line_slot_nxt;
      tbl_vld_r   <= tbl_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    pos_r      <= pos_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Slot table: ring position -> physical row and token length
  clt_ram #(
    .WIDTH ($bits(clt_slot_t)),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (pos_r),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Character rows, one per physical slot
  clt_ram #(
    .WIDTH (8),
    .DEPTH (CHR_DEPTH)
  ) u_chr_ram (
    .clk   (clk),
    .we    (chr_we),
    .waddr (chr_waddr),
    .wdata (chr_wdata),
    .re    (chr_re),
    .raddr (chr_raddr),
    .rdata (chr_rdata)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TOKENS_MAX))
    else $error("token count above table size");

  a_line_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_slot_r <= PHY_W'(TOKENS_MAX))
    else $error("line buffer row out of range");

  a_mem_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(tbl_we && tbl_re) && !(chr_we && chr_re))
    else $error("read and write of one memory in the same cycle");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result presented outside the hand-over step");

  a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.event_res == EV_COMMIT |-> out_data_r.token_count != 4'd0)
    else $error("commit reported with an empty table");
`endif

endmodule
